FILE: hw/rtl/multi_row_step_sequencer_macros.svh
`ifndef MULTI_ROW_STEP_SEQUENCER_MACROS_SVH
`define MULTI_ROW_STEP_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MRSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrss check failed");

// next-cycle implication, checked outside reset
`define MRSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrss check failed");

// next-cycle implication, checked during reset too
`define MRSS_ASSERT_ALWAYS_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mrss check failed");

`endif

FILE: hw/rtl/mrss_pkg.sv
`default_nettype none

package mrss_pkg;

    localparam int ROWS  = 4;
    localparam int STEPS = 16;
    localparam int LANES = 2;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int POS_W  = $clog2(STEPS);
    localparam int LANE_W = $clog2(LANES);
    localparam int CNT_W  = $clog2(STEPS + 1);

    localparam int VAL_W        = 12;
    localparam int CFG_W        = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int TOG_ADDR_W   = 7;
    localparam int VAL_ADDR_W   = 6;
    localparam int GATE_W       = 8;
    localparam int OUT_POS_W    = 4;

    localparam logic [CFG_W-1:0] STEPS_RESET = CFG_W'(16);

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic rise;
        logic level;
    } t_chain;

    typedef struct packed {
        logic go;
        logic rst_rise;
    } t_tick;

    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  step;
        logic [LANE_W-1:0] lane;
    } t_toggle;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] step;
        logic [VAL_W-1:0] data;
    } t_wr;

endpackage

`default_nettype wire

FILE: hw/rtl/mrss_row.sv
`default_nettype none

module mrss_row
    import mrss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tick             i_tick,
    input  wire logic              i_patched,
    input  wire logic              i_level,
    input  wire t_chain            i_chain,
    input  wire logic [CFG_W-1:0]  i_steps,
    input  wire t_toggle           i_toggle,
    input  wire t_wr               i_wr,
    output t_chain                 o_chain,
    output logic [VAL_W-1:0]       o_value,
    output logic [POS_W-1:0]       o_position,
    output logic [LANES-1:0]       o_gates
);

    logic                r_last;
    logic [POS_W-1:0]    r_pos;
    logic [LANES-1:0]    r_gate [STEPS];
    logic [VAL_W-1:0]    r_val [STEPS];

    logic [CNT_W-1:0]    active;
    logic [CNT_W-1:0]    nxt;
    logic [POS_W-1:0]    pos_step;
    logic [POS_W-1:0]    n_pos;

    always_comb begin
        if (i_patched) begin
            o_chain.rise  = i_level & ~r_last;
            o_chain.level = i_level;
        end else begin
            o_chain = i_chain;
        end
    end

    // step count clamped to 1..STEPS
    always_comb begin
        if (i_steps == '0) begin
            active = CNT_W'(1);
        end else if (32'(i_steps) > 32'(STEPS)) begin
            active = CNT_W'(STEPS);
        end else begin
            active = CNT_W'(i_steps);
        end
    end

    always_comb begin
        nxt = CNT_W'(r_pos) + CNT_W'(1);
        if (o_chain.rise) begin
            pos_step = (nxt >= active) ? '0 : nxt[POS_W-1:0];
        end else begin
            pos_step = r_pos;
        end
        n_pos = i_tick.rst_rise ? '0 : pos_step;
    end

    // toggle of this tick is seen by the result
    always_comb begin
        for (int g = 0; g < LANES; g++) begin
            o_gates[g] = o_chain.level & (r_gate[n_pos][g] ^ (i_toggle.hit
                         && i_toggle.step == n_pos && i_toggle.lane == LANE_W'(g)));
        end
    end

    assign o_value    = r_val[n_pos];
    assign o_position = n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
            r_pos  <= '0;
            for (int s = 0; s < STEPS; s++) begin
                r_gate[s] <= '1;
                r_val[s]  <= '0;
            end
        end else begin
            if (i_tick.go) begin
                if (i_patched) begin
                    r_last <= i_level;
                end
                r_pos <= n_pos;
            end
            if (i_toggle.hit) begin
                r_gate[i_toggle.step][i_toggle.lane] <=
                    ~r_gate[i_toggle.step][i_toggle.lane];
            end
            if (i_wr.en) begin
                r_val[i_wr.step] <= i_wr.data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/multi_row_step_sequencer.sv
// Four-row step sequencer with two gate lanes per row. Beats enter through an input
// register and leave through a result register; a new beat is taken every clock unless
// the input side stalls, and a tick beat's result is loaded as it leaves the input register.
// Write beats load one step value and give no result. Step counts are to be written on the
// configuration port only while idle, not enforced by the block; 0 acts as 1 and values
// above 16 act as 16. The input side stalls only while a result waits on a stalled output.
`default_nettype none

module multi_row_step_sequencer
    import mrss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_operation,
    input  wire logic [3:0]            i_clock_levels,
    input  wire logic [3:0]            i_clock_patched,
    input  wire logic                  i_reset_level,
    input  wire logic                  i_toggle_valid,
    input  wire logic [TOG_ADDR_W-1:0] i_toggle_address,
    input  wire logic [VAL_ADDR_W-1:0] i_value_address,
    input  wire logic [VAL_W-1:0]      i_value_data,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [GATE_W-1:0]          o_gate_bits,
    output logic [VAL_W-1:0]           o_value_row0,
    output logic [VAL_W-1:0]           o_value_row1,
    output logic [VAL_W-1:0]           o_value_row2,
    output logic [VAL_W-1:0]           o_value_row3,
    output logic [OUT_POS_W-1:0]       o_position_row0,
    output logic [OUT_POS_W-1:0]       o_position_row1,
    output logic [OUT_POS_W-1:0]       o_position_row2,
    output logic [OUT_POS_W-1:0]       o_position_row3
);

    logic                  r_s1_vld;
    logic                  r_op;
    logic [3:0]            r_levels;
    logic [3:0]            r_patched;
    logic                  r_rst_lvl;
    logic                  r_tog_vld;
    logic [TOG_ADDR_W-1:0] r_tog_addr;
    logic [VAL_ADDR_W-1:0] r_val_addr;
    logic [VAL_W-1:0]      r_val_data;

    logic                  r_last_rst;
    logic [CFG_W-1:0]      r_steps [ROWS];

    logic                  r_out_vld;
    logic [GATE_W-1:0]     r_out_gates;
    logic [VAL_W-1:0]      r_out_value [ROWS];
    logic [OUT_POS_W-1:0]  r_out_pos [ROWS];

    logic                  in_acc;
    logic                  out_free;
    logic                  s1_go;
    logic                  tick_go;
    logic                  wr_go;
    t_tick                 tick;
    t_chain                chain [ROWS+1];
    logic [VAL_W-1:0]      row_value [ROWS];
    logic [POS_W-1:0]      row_pos [ROWS];
    logic [LANES-1:0]      row_gates [ROWS];
    logic [GATE_W-1:0]     gates;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_go      = r_s1_vld && (r_op == OP_WRITE || out_free);
    assign tick_go    = s1_go && r_op == OP_TICK;
    assign wr_go      = s1_go && r_op == OP_WRITE;
    assign o_in_stall = r_s1_vld && !s1_go;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign tick.go       = tick_go;
    assign tick.rst_rise = r_rst_lvl & ~r_last_rst;
    assign chain[0]      = '0;

    for (genvar r = 0; r < ROWS; r++) begin : g_row
        t_toggle tog;
        t_wr     wr;

        assign tog.hit  = tick_go && r_tog_vld
                          && r_tog_addr[LANE_W+POS_W +: ROW_W] == ROW_W'(r);
        assign tog.step = r_tog_addr[LANE_W +: POS_W];
        assign tog.lane = r_tog_addr[LANE_W-1:0];
        assign wr.en    = wr_go && r_val_addr[POS_W +: ROW_W] == ROW_W'(r);
        assign wr.step  = r_val_addr[POS_W-1:0];
        assign wr.data  = r_val_data;

        mrss_row u_row (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tick     (tick),
            .i_patched  (r_patched[r]),
            .i_level    (r_levels[r]),
            .i_chain    (chain[r]),
            .i_steps    (r_steps[r]),
            .i_toggle   (tog),
            .i_wr       (wr),
            .o_chain    (chain[r+1]),
            .o_value    (row_value[r]),
            .o_position (row_pos[r]),
            .o_gates    (row_gates[r])
        );
    end

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            for (int g = 0; g < LANES; g++) begin
                gates[r*LANES+g] = row_gates[r][g];
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_operation;
            r_levels   <= i_clock_levels;
            r_patched  <= i_clock_patched;
            r_rst_lvl  <= i_reset_level;
            r_tog_vld  <= i_toggle_valid;
            r_tog_addr <= i_toggle_address;
            r_val_addr <= i_value_address;
            r_val_data <= i_value_data;
        end
    end

    // reset edge detector and step counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rst <= 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                r_steps[r] <= STEPS_RESET;
            end
        end else begin
            if (tick_go) begin
                r_last_rst <= r_rst_lvl;
            end
            if (i_cfg_we && 32'(i_cfg_index) < 32'(ROWS)) begin
                r_steps[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (tick_go) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_out_gates <= gates;
            for (int r = 0; r < ROWS; r++) begin
                r_out_value[r] <= row_value[r];
                r_out_pos[r]   <= OUT_POS_W'(row_pos[r]);
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_gate_bits     = r_out_gates;
    assign o_value_row0    = r_out_value[0];
    assign o_value_row1    = r_out_value[1];
    assign o_value_row2    = r_out_value[2];
    assign o_value_row3    = r_out_value[3];
    assign o_position_row0 = r_out_pos[0];
    assign o_position_row1 = r_out_pos[1];
    assign o_position_row2 = r_out_pos[2];
    assign o_position_row3 = r_out_pos[3];

endmodule

`default_nettype wire

FILE: hw/rtl/mrss_checker.sv
`default_nettype none
`include "multi_row_step_sequencer_macros.svh"

module mrss_checker
    import mrss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  o_in_stall,
    input  wire logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [GATE_W-1:0]     o_gate_bits,
    input  wire logic [VAL_W-1:0]      o_value_row0,
    input  wire logic [OUT_POS_W-1:0]  o_position_row3
);

    // a stalled result beat holds
    `MRSS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_gate_bits))
    `MRSS_ASSERT_NEXT(a_hold_value, o_out_valid && i_out_stall, $stable(o_value_row0))
    `MRSS_ASSERT_NEXT(a_hold_pos, o_out_valid && i_out_stall, $stable(o_position_row3))

    // input side backs up only behind a blocked result
    `MRSS_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // no result beat straight out of reset
    `MRSS_ASSERT_ALWAYS_NEXT(a_rst_quiet, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind multi_row_step_sequencer mrss_checker u_mrss_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mrss_pkg::*;

    typedef struct packed {
        logic                  op;
        logic [3:0]            clk_lv;
        logic [3:0]            patched;
        logic                  rst_lv;
        logic                  tog_en;
        logic [TOG_ADDR_W-1:0] tog_addr;
        logic [VAL_ADDR_W-1:0] val_addr;
        logic [VAL_W-1:0]      val_data;
    } beat_t;

    typedef struct packed {
        logic [GATE_W-1:0]               gates;
        logic [3:0][VAL_W-1:0]           value;
        logic [3:0][OUT_POS_W-1:0]       pos;
    } step_out_t;

    typedef struct packed {
        beat_t     beat;
        logic      known;
        step_out_t want;
    } plan_row_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEPS_ROW0,
        REG_STEPS_ROW1,
        REG_STEPS_ROW2,
        REG_STEPS_ROW3
    } steps_reg_e;

    localparam int PLAN_ROWS   = 22;
    localparam int PHASES      = 5;
    localparam int PHASE_BEATS = 150;
    localparam int HOLD_LEN    = 120;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_operation = OP_TICK;
    logic [3:0]            i_clock_levels = '0;
    logic [3:0]            i_clock_patched = '0;
    logic                  i_reset_level = 1'b0;
    logic                  i_toggle_valid = 1'b0;
    logic [TOG_ADDR_W-1:0] i_toggle_address = '0;
    logic [VAL_ADDR_W-1:0] i_value_address = '0;
    logic [VAL_W-1:0]      i_value_data = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_STEPS_ROW0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [GATE_W-1:0]     o_gate_bits;
    logic [VAL_W-1:0]      o_value_row0, o_value_row1, o_value_row2, o_value_row3;
    logic [OUT_POS_W-1:0]  o_position_row0, o_position_row1;
    logic [OUT_POS_W-1:0]  o_position_row2, o_position_row3;

    multi_row_step_sequencer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_clock_levels   (i_clock_levels),
        .i_clock_patched  (i_clock_patched),
        .i_reset_level    (i_reset_level),
        .i_toggle_valid   (i_toggle_valid),
        .i_toggle_address (i_toggle_address),
        .i_value_address  (i_value_address),
        .i_value_data     (i_value_data),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_gate_bits      (o_gate_bits),
        .o_value_row0     (o_value_row0),
        .o_value_row1     (o_value_row1),
        .o_value_row2     (o_value_row2),
        .o_value_row3     (o_value_row3),
        .o_position_row0  (o_position_row0),
        .o_position_row1  (o_position_row1),
        .o_position_row2  (o_position_row2),
        .o_position_row3  (o_position_row3)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // sequencer image
    logic [ROWS*STEPS*LANES-1:0] gate_mem = '1;
    logic [VAL_W-1:0]            step_value_mem [ROWS*STEPS];
    logic [POS_W-1:0]            row_pos [ROWS];
    logic [ROWS-1:0]             clk_last = '0;
    logic                        rst_last = 1'b0;
    logic [CFG_W-1:0]            step_count [ROWS];

    step_out_t step_results_due [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;
    int mismatches = 0;
    int results_seen = 0;
    int ticks_sent = 0;
    int writes_sent = 0;
    int quiet_cycles = 0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{'{OP_TICK,  4'h0, 4'h0, 1'b0, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b1,
          '{8'h00, 48'h0, 16'h0000}},
        '{'{OP_TICK,  4'hF, 4'hF, 1'b0, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b1,
          '{8'hFF, 48'h0, 16'h1111}},
        '{'{OP_WRITE, 4'hF, 4'hF, 1'b1, 1'b1, 7'h7F, 6'h3F, 12'hFFF}, 1'b0, '0},
        '{'{OP_WRITE, 4'h0, 4'h0, 1'b0, 1'b0, 7'h00, 6'h01, 12'hABC}, 1'b0, '0},
        '{'{OP_WRITE, 4'h0, 4'h0, 1'b0, 1'b0, 7'h00, 6'h11, 12'h800}, 1'b0, '0},
        '{'{OP_TICK,  4'hF, 4'hF, 1'b0, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b1,
          '{8'hFF, 48'h000_000_800_ABC, 16'h1111}},
        '{'{OP_TICK,  4'h0, 4'hF, 1'b0, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b1,
          '{8'h00, 48'h000_000_800_ABC, 16'h1111}},
        '{'{OP_TICK,  4'h1, 4'h1, 1'b0, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b1,
          '{8'hFF, 48'h0, 16'h2222}},
        '{'{OP_TICK,  4'h0, 4'h0, 1'b0, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b1,
          '{8'h00, 48'h0, 16'h2222}},
        '{'{OP_TICK,  4'h0, 4'hF, 1'b1, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b1,
          '{8'h00, 48'h0, 16'h0000}},
        '{'{OP_TICK,  4'hF, 4'hF, 1'b1, 1'b1, 7'h01, 6'h00, 12'h000}, 1'b1,
          '{8'hFF, 48'h000_000_800_ABC, 16'h1111}},
        '{'{OP_TICK,  4'hF, 4'hF, 1'b0, 1'b1, 7'h02, 6'h00, 12'h000}, 1'b1,
          '{8'hFE, 48'h000_000_800_ABC, 16'h1111}},
        '{'{OP_TICK,  4'hF, 4'hF, 1'b1, 1'b1, 7'h7F, 6'h00, 12'h000}, 1'b1,
          '{8'hFD, 48'h0, 16'h0000}},
        '{'{OP_TICK,  4'hA, 4'hA, 1'b0, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b0, '0},
        '{'{OP_TICK,  4'h0, 4'h5, 1'b0, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b0, '0},
        '{'{OP_TICK,  4'hF, 4'h5, 1'b0, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b0, '0},
        '{'{OP_WRITE, 4'h0, 4'h0, 1'b0, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b0, '0},
        '{'{OP_WRITE, 4'h0, 4'h0, 1'b0, 1'b0, 7'h00, 6'h20, 12'h555}, 1'b0, '0},
        '{'{OP_TICK,  4'hF, 4'hF, 1'b0, 1'b1, 7'h00, 6'h3F, 12'hFFF}, 1'b0, '0},
        '{'{OP_TICK,  4'h0, 4'hF, 1'b0, 1'b1, 7'h40, 6'h00, 12'h000}, 1'b0, '0},
        '{'{OP_TICK,  4'hF, 4'h0, 1'b1, 1'b0, 7'h00, 6'h00, 12'h000}, 1'b0, '0},
        '{'{OP_TICK,  4'h3, 4'hC, 1'b0, 1'b1, 7'h7E, 6'h00, 12'h000}, 1'b0, '0}
    };

    logic [CFG_W-1:0] steps_plan [PHASES][ROWS] = '{
        '{5'd0,  5'd31, 5'd1,  5'd16},
        '{5'd17, 5'd2,  5'd5,  5'd3},
        '{5'd1,  5'd16, 5'd7,  5'd0},
        '{5'd16, 5'd16, 5'd16, 5'd16},
        '{5'd16, 5'd16, 5'd16, 5'd16}
    };
    int send_idle_plan [PHASES] = '{0, 70, 0, 17, 0};
    int recv_stall_plan [PHASES] = '{0, 0, 70, 17, 0};

    initial begin
        for (int a = 0; a < ROWS*STEPS; a++) step_value_mem[a] = '0;
        for (int r = 0; r < ROWS; r++) begin
            row_pos[r] = '0;
            step_count[r] = STEPS_RESET;
        end
    end

    task automatic advance_sequencer(input beat_t b, output bit made, output step_out_t res);
        logic             rise;
        logic             lvl;
        logic [ROWS-1:0]  row_lvl;
        logic [CFG_W-1:0] span;
        logic [CFG_W-1:0] nxt;
        int               ga;
        made = 1'b0;
        res = '0;
        rise = 1'b0;
        lvl = 1'b0;
        if (b.op == OP_WRITE) begin
            step_value_mem[b.val_addr] = b.val_data;
        end else begin
            made = 1'b1;
            for (int r = 0; r < ROWS; r++) begin
                if (b.patched[r]) begin
                    rise = b.clk_lv[r] & ~clk_last[r];
                    lvl = b.clk_lv[r];
                    clk_last[r] = b.clk_lv[r];
                end else if (r == 0) begin
                    rise = 1'b0;
                    lvl = 1'b0;
                end
                row_lvl[r] = lvl;
                if (rise) begin
                    span = step_count[r];
                    if (span == 0)
                        span = CFG_W'(1);
                    else if (span > STEPS)
                        span = CFG_W'(STEPS);
                    nxt = {1'b0, row_pos[r]} + 1'b1;
                    row_pos[r] = (nxt >= span) ? '0 : nxt[POS_W-1:0];
                end
            end
            if (b.rst_lv && !rst_last) begin
                for (int r = 0; r < ROWS; r++) row_pos[r] = '0;
            end
            rst_last = b.rst_lv;
            if (b.tog_en)
                gate_mem[b.tog_addr] = ~gate_mem[b.tog_addr];
            for (int r = 0; r < ROWS; r++) begin
                for (int g = 0; g < LANES; g++) begin
                    ga = (r * STEPS + row_pos[r]) * LANES + g;
                    res.gates[r*LANES+g] = row_lvl[r] & gate_mem[ga];
                end
                res.value[r] = step_value_mem[r*STEPS+row_pos[r]];
                res.pos[r] = row_pos[r];
            end
        end
    endtask

    task automatic send_beat(input beat_t b, output bit made, output step_out_t res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= b.op;
        i_clock_levels   <= b.clk_lv;
        i_clock_patched  <= b.patched;
        i_reset_level    <= b.rst_lv;
        i_toggle_valid   <= b.tog_en;
        i_toggle_address <= b.tog_addr;
        i_value_address  <= b.val_addr;
        i_value_data     <= b.val_data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_sequencer(b, made, res);
        if (made)
            ticks_sent++;
        else
            writes_sent++;
    endtask

    task automatic drain_results();
        while (step_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic program_steps(input logic [CFG_W-1:0] counts [ROWS]);
        for (int r = 0; r < ROWS; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= steps_reg_e'(r);
            i_cfg_data  <= counts[r];
            @(posedge i_clk);
            step_count[r] = counts[r];
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic beat_t random_beat();
        beat_t b;
        b.op       = ($urandom_range(99) < 15) ? OP_WRITE : OP_TICK;
        b.clk_lv   = 4'($urandom);
        b.patched  = $urandom_range(1) ? 4'hF : 4'($urandom);
        b.rst_lv   = ($urandom_range(9) == 0);
        b.tog_en   = ($urandom_range(3) == 0);
        b.tog_addr = 7'($urandom);
        b.val_addr = 6'($urandom);
        case ($urandom_range(7))
            0: b.val_data = '0;
            1: b.val_data = '1;
            default: b.val_data = 12'($urandom);
        endcase
        return b;
    endfunction

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_LEN) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= hold_cnt + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        step_out_t got;
        step_out_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.gates = o_gate_bits;
            got.value = {o_value_row3, o_value_row2, o_value_row1, o_value_row0};
            got.pos   = {o_position_row3, o_position_row2, o_position_row1, o_position_row0};
            results_seen++;
            if (step_results_due.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %h", $time, got);
                mismatches++;
            end else begin
                want = step_results_due.pop_front();
                if (got.gates !== want.gates) begin
                    $display("%0t gate_bits: expected %h, actual %h",
                             $time, want.gates, got.gates);
                    mismatches++;
                end
                for (int r = 0; r < ROWS; r++) begin
                    if (got.value[r] !== want.value[r]) begin
                        $display("%0t value_row%0d: expected %h, actual %h",
                                 $time, r, want.value[r], got.value[r]);
                        mismatches++;
                    end
                    if (got.pos[r] !== want.pos[r]) begin
                        $display("%0t position_row%0d: expected %h, actual %h",
                                 $time, r, want.pos[r], got.pos[r]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, step_results_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        beat_t            b;
        bit               made;
        step_out_t        res;
        logic [CFG_W-1:0] counts [ROWS];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            send_beat(plan[i].beat, made, res);
            if (made)
                step_results_due.push_back(plan[i].known ? plan[i].want : res);
        end
        i_in_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            for (int r = 0; r < ROWS; r++)
                counts[r] = (p == 3) ? CFG_W'($urandom_range(31)) : steps_plan[p][r];
            program_steps(counts);
            send_idle_pct = send_idle_plan[p];
            recv_stall_pct <= recv_stall_plan[p];
            // long output hold while the input keeps offering beats
            if (p == 0)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                b = random_beat();
                send_beat(b, made, res);
                if (made)
                    step_results_due.push_back(res);
            end
            i_in_valid <= 1'b0;
        end

        drain_results();
        $display("covered %0d tick beats and %0d write beats, %0d results checked,",
                 ticks_sent, writes_sent, results_seen);
        $display("over %0d step-count settings with idle, stall and long-hold phases",
                 PHASES + 1);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
